// ===== sv/frm_pkg.sv =====
// Shared types and constants of the frame rate meter.
`timescale 1ns / 1ps
`default_nettype none
package frm_pkg;

	localparam int RATE_COUNT   = 3;
	localparam int HEADER_BYTES = 14;
	localparam int NUM_STATS    = 4;
	localparam int NUM_CFG      = 3;
	localparam int FRONT_DEPTH  = 2;
	localparam int DIV_STEPS    = 33;

	localparam int RIDX_W  = (RATE_COUNT > 1) ? $clog2(RATE_COUNT) : 1;
	localparam int SIDX_W  = $clog2(NUM_STATS);
	localparam int FPTR_W  = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
	localparam int FCNT_W  = $clog2(FRONT_DEPTH + 1);
	localparam int DCNT_W  = $clog2(DIV_STEPS + 1);
	localparam int ADD_W   = 12;

	localparam logic [31:0] FRAME_SCALE = 32'd1000;

	localparam logic [NUM_CFG-1:0][15:0] IVAL_RESET = {16'd60, 16'd10, 16'd1};

	// stat lanes within one row of averages
	localparam logic [SIDX_W-1:0] STAT_TX_FRM = 2'd0;
	localparam logic [SIDX_W-1:0] STAT_RX_FRM = 2'd1;
	localparam logic [SIDX_W-1:0] STAT_TX_BYT = 2'd2;
	localparam logic [SIDX_W-1:0] STAT_RX_BYT = 2'd3;

	typedef enum logic [2:0] {
		KIND_TX_OK   = 3'd0,
		KIND_TX_FAIL = 3'd1,
		KIND_RX      = 3'd2,
		KIND_TICK    = 3'd3,
		KIND_CLEAR   = 3'd4
	} frm_kind_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TX_OK,
		OP_TX_FAIL,
		OP_RX,
		OP_TICK,
		OP_CLEAR
	} frm_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_TICK_DONE,
		ST_EMIT
	} frm_state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [10:0] frame_bytes;
	} frm_in_t;

	typedef struct packed {
		logic [1:0]         interval_index;
		logic signed [31:0] tx_frame_smooth;
		logic signed [31:0] rx_frame_smooth;
		logic signed [31:0] tx_byte_smooth;
		logic signed [31:0] rx_byte_smooth;
		logic [31:0]        tx_frames;
		logic [31:0]        rx_frames;
		logic [31:0]        tx_byte_total;
		logic [31:0]        rx_byte_total;
		logic [31:0]        tx_error_count;
		logic               last;
	} frm_out_t;

	// classified request from front to back
	typedef struct packed {
		frm_op_t          op;
		logic [ADD_W-1:0] add_bytes;
	} frm_req_t;

	typedef struct packed {
		logic               start;
		logic signed [32:0] dividend;
		logic [15:0]        divisor;
	} frm_div_req_t;

	typedef logic [NUM_STATS-1:0][31:0] frm_row_t;

endpackage
`default_nettype wire

// ===== sv/frm_front.sv =====
// Input queue of the frame rate meter: accepts events and classifies them.
`timescale 1ns / 1ps
`default_nettype none
module frm_front (
	input  wire              clk,
	input  wire              arst_n,
	input  frm_pkg::frm_in_t item,
	input  wire              push,
	output logic             full,
	output frm_pkg::frm_req_t req,
	output logic             req_valid,
	input  wire              req_take
);
	import frm_pkg::*;

	frm_req_t          fifo_q [FRONT_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [FCNT_W-1:0] count_q;
	frm_req_t          cls;
	logic              do_push;
	logic              do_pop;

	always_comb begin
		cls.op        = OP_NONE;
		cls.add_bytes = ADD_W'(item.frame_bytes);
		case (frm_kind_t'(item.kind))
			KIND_TX_OK: begin
				cls.op        = OP_TX_OK;
				cls.add_bytes = ADD_W'(item.frame_bytes) + ADD_W'(HEADER_BYTES);
			end
			KIND_TX_FAIL: cls.op = OP_TX_FAIL;
			KIND_RX:      cls.op = OP_RX;
			KIND_TICK:    cls.op = OP_TICK;
			KIND_CLEAR:   cls.op = OP_CLEAR;
			default:      cls.op = OP_NONE;
		endcase
	end

	assign full      = (count_q == FCNT_W'(FRONT_DEPTH));
	assign req_valid = (count_q != '0);
	assign req       = fifo_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = req_take && req_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FPTR_W'(FRONT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FPTR_W'(FRONT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FCNT_W'(do_push) - FCNT_W'(do_pop);
		end
	end

endmodule
`default_nettype wire

// ===== sv/frm_div.sv =====
// Bit-serial signed divider, quotient truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none
module frm_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  frm_pkg::frm_div_req_t div_req,
	output logic                 done,
	output logic signed [33:0]   quotient
);
	import frm_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [15:0]       rem_q;
	logic [32:0]       quo_q;
	logic [15:0]       dvs_q;
	logic              neg_q;
	logic [16:0]       shifted;
	logic              fits;
	logic [32:0]       mag;

	assign shifted = {rem_q, quo_q[32]};
	assign fits    = (shifted >= {1'b0, dvs_q});
	assign mag     = div_req.dividend[32] ? 33'(-div_req.dividend) : 33'(div_req.dividend);

	always_ff @(posedge clk) begin
		if (div_req.start) begin
			rem_q <= '0;
			quo_q <= mag;
			dvs_q <= div_req.divisor;
			neg_q <= div_req.dividend[32];
		end else if (busy_q) begin
			rem_q <= fits ? 16'(shifted - {1'b0, dvs_q}) : shifted[15:0];
			quo_q <= {quo_q[31:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (div_req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule
`default_nettype wire

// ===== sv/frm_back.sv =====
// Statistics engine: counters, smoothed rates, result register.
`timescale 1ns / 1ps
`default_nettype none
module frm_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  frm_pkg::frm_req_t     req,
	input  wire                   req_valid,
	output logic                  req_take,
	input  wire                   wr_en,
	input  wire  [1:0]            wr_index,
	input  wire  [15:0]           wr_data,
	output frm_pkg::frm_div_req_t div_req,
	input  wire                   div_done,
	input  wire  signed [33:0]    div_quotient,
	output frm_pkg::frm_out_t     result,
	output logic                  empty,
	input  wire                   pop
);
	import frm_pkg::*;

	frm_state_t        state_q;
	frm_state_t        state_d;
	logic              load_out;

	logic [NUM_CFG-1:0][15:0] ival_q;
	logic [31:0]       tx_frm_q, rx_frm_q, tx_byt_q, rx_byt_q, tx_err_q;
	logic [31:0]       tx_frm_snap_q, rx_frm_snap_q, tx_byt_snap_q, rx_byt_snap_q;
	frm_row_t          avg_q [RATE_COUNT];
	frm_row_t          x_q;
	logic [RIDX_W-1:0] idx_q;
	logic [SIDX_W-1:0] j_q;

	frm_out_t          out_q;
	logic              out_valid_q;

	logic [15:0]       ival;
	logic [31:0]       avg_cur;
	logic [31:0]       x_cur;
	logic [33:0]       avg_next;
	frm_row_t          avg_row;

	assign ival     = ival_q[idx_q];
	assign avg_row  = avg_q[idx_q];
	assign avg_cur  = avg_row[j_q];
	assign x_cur    = x_q[j_q];
	assign avg_next = {{2{avg_cur[31]}}, avg_cur} + 34'(div_quotient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		req_take         = 1'b0;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = $signed({x_cur[31], x_cur}) - $signed({avg_cur[31], avg_cur});
		// a zero interval acts as one
		div_req.divisor  = (ival == '0) ? 16'd1 : ival;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_take = 1'b1;
					state_d  = (req.op == OP_TICK) ? ST_PREP : ST_EMIT;
				end
			end
			ST_PREP: state_d = ST_DIV_START;
			ST_DIV_START: begin
				div_req.start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					if (j_q == SIDX_W'(NUM_STATS - 1) && idx_q == RIDX_W'(RATE_COUNT - 1)) begin
						state_d = ST_TICK_DONE;
					end else begin
						state_d = ST_DIV_START;
					end
				end
			end
			ST_TICK_DONE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					if (idx_q == RIDX_W'(RATE_COUNT - 1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ival_q        <= IVAL_RESET;
			tx_frm_q      <= '0;
			rx_frm_q      <= '0;
			tx_byt_q      <= '0;
			rx_byt_q      <= '0;
			tx_err_q      <= '0;
			tx_frm_snap_q <= '0;
			rx_frm_snap_q <= '0;
			tx_byt_snap_q <= '0;
			rx_byt_snap_q <= '0;
			for (int r = 0; r < RATE_COUNT; r++) begin
				avg_q[r] <= '0;
			end
			x_q           <= '0;
			idx_q         <= '0;
			j_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (wr_en && wr_index < 2'(NUM_CFG)) begin
				ival_q[wr_index] <= wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					j_q   <= '0;
					if (req_valid) begin
						case (req.op)
							OP_TX_OK: begin
								tx_frm_q <= tx_frm_q + 32'd1;
								tx_byt_q <= tx_byt_q + 32'(req.add_bytes);
							end
							OP_TX_FAIL: tx_err_q <= tx_err_q + 32'd1;
							OP_RX: begin
								rx_frm_q <= rx_frm_q + 32'd1;
								rx_byt_q <= rx_byt_q + 32'(req.add_bytes);
							end
							OP_CLEAR: begin
								tx_frm_q      <= '0;
								rx_frm_q      <= '0;
								tx_byt_q      <= '0;
								rx_byt_q      <= '0;
								tx_err_q      <= '0;
								tx_frm_snap_q <= '0;
								rx_frm_snap_q <= '0;
								tx_byt_snap_q <= '0;
								rx_byt_snap_q <= '0;
								for (int r = 0; r < RATE_COUNT; r++) begin
									avg_q[r] <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PREP: begin
					x_q[STAT_TX_FRM] <= 32'((tx_frm_q - tx_frm_snap_q) * FRAME_SCALE);
					x_q[STAT_RX_FRM] <= 32'((rx_frm_q - rx_frm_snap_q) * FRAME_SCALE);
					x_q[STAT_TX_BYT] <= tx_byt_q - tx_byt_snap_q;
					x_q[STAT_RX_BYT] <= rx_byt_q - rx_byt_snap_q;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						avg_q[idx_q][j_q] <= avg_next[31:0];
						if (j_q == SIDX_W'(NUM_STATS - 1)) begin
							j_q   <= '0;
							idx_q <= idx_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_TICK_DONE: begin
					tx_frm_snap_q <= tx_frm_q;
					rx_frm_snap_q <= rx_frm_q;
					tx_byt_snap_q <= tx_byt_q;
					rx_byt_snap_q <= rx_byt_q;
					idx_q         <= '0;
				end
				ST_EMIT: begin
					if (load_out) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.interval_index  <= 2'(idx_q);
			out_q.tx_frame_smooth <= avg_row[STAT_TX_FRM];
			out_q.rx_frame_smooth <= avg_row[STAT_RX_FRM];
			out_q.tx_byte_smooth  <= avg_row[STAT_TX_BYT];
			out_q.rx_byte_smooth  <= avg_row[STAT_RX_BYT];
			out_q.tx_frames       <= tx_frm_q;
			out_q.rx_frames       <= rx_frm_q;
			out_q.tx_byte_total   <= tx_byt_q;
			out_q.rx_byte_total   <= rx_byt_q;
			out_q.tx_error_count  <= tx_err_q;
			out_q.last            <= (idx_q == RIDX_W'(RATE_COUNT - 1));
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

endmodule
`default_nettype wire

// ===== sv/frame_rate_meter.sv =====
// Top level of the frame rate meter.
//
//  channel   | handshake        | payload
//  ----------+------------------+------------------------------------
//  events    | push / full      | item   (kind, frame_bytes)
//  results   | pop / empty      | result (interval, rates, totals, last)
//  registers | wr_en            | wr_index, wr_data (three intervals)
//
// A frame event, failed send, clear or unknown kind first updates the
// counters, then loads each result in turn into the output register.
// A tick runs the single serial divider (33 steps) once for each of the
// 4 rates at each of the 3 intervals, then emits the results likewise.
// Two requests queue ahead of the engine; full rises only when both wait.
// A result not popped holds the engine; reset clears all statistics at once.
`timescale 1ns / 1ps
`default_nettype none
module frame_rate_meter (
	input  wire               clk,
	input  wire               arst_n,
	input  frm_pkg::frm_in_t  item,
	input  wire               push,
	output logic              full,
	output frm_pkg::frm_out_t result,
	output logic              empty,
	input  wire               pop,
	input  wire               wr_en,
	input  wire  [1:0]        wr_index,
	input  wire  [15:0]       wr_data
);
	import frm_pkg::*;

	frm_req_t           req;
	logic               req_valid;
	logic               req_take;
	frm_div_req_t       div_req;
	logic               div_done;
	logic signed [33:0] div_quotient;

	frm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.push      (push),
		.full      (full),
		.req       (req),
		.req_valid (req_valid),
		.req_take  (req_take)
	);

	frm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.div_req  (div_req),
		.done     (div_done),
		.quotient (div_quotient)
	);

	frm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.req_valid    (req_valid),
		.req_take     (req_take),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.div_req      (div_req),
		.div_done     (div_done),
		.div_quotient (div_quotient),
		.result       (result),
		.empty        (empty),
		.pop          (pop)
	);

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.last == (result.interval_index == 2'(RATE_COUNT - 1))))
		else $error("last flag does not match final interval");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.interval_index < 2'(RATE_COUNT)))
		else $error("interval index out of range");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |-> req_valid)
		else $error("engine took a request from an empty queue");

	a_div_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !div_req.start && !div_done)
		else $error("divider restarted or finished too early");

endmodule
`default_nettype wire
